>>> rtl/sds_pkg.sv
// Shared types and constants of the sorted deque store.
package sds_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W = 32;
  localparam int ID_W = 40;
  localparam int NAME_W = 16;

  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_SORTED    = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_POP_TAIL  = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_READ_ALL  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
    logic [NAME_W-1:0]       name;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;       // capture the incoming record and its insert position
    logic ins;       // apply the captured insert
    logic pop_h;
    logic pop_t;
    logic clr;
    logic rd_load;
    logic rd_step;
    logic res_ok;
    logic res_empty;
    logic res_full;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic rd_last;
  } sts_t;

endpackage

>>> rtl/sds_ctrl.sv
// Controller state machine of the sorted deque store.
module sds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        operation,
  input  sds_pkg::sts_t     sts,
  output sds_pkg::cmd_t     cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_READ   = 3'b100
  } state_t;

  state_t state, state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (sds_pkg::op_t'(operation)) inside
            sds_pkg::OP_PUSH_HEAD, sds_pkg::OP_PUSH_TAIL, sds_pkg::OP_SORTED: begin
              if (sts.full) begin
                cmd.res_full = 1'b1;
              end else begin
                cmd.cap = 1'b1;
                state_next = ST_INSERT;
              end
            end
            sds_pkg::OP_POP_HEAD: begin
              if (sts.empty) cmd.res_empty = 1'b1;
              else cmd.pop_h = 1'b1;
            end
            sds_pkg::OP_POP_TAIL: begin
              if (sts.empty) cmd.res_empty = 1'b1;
              else cmd.pop_t = 1'b1;
            end
            sds_pkg::OP_CLEAR: begin
              cmd.clr = 1'b1;
              cmd.res_ok = 1'b1;
            end
            sds_pkg::OP_READ_ALL: begin
              if (sts.empty) begin
                cmd.res_empty = 1'b1;
              end else begin
                cmd.rd_load = 1'b1;
                state_next = ST_READ;
              end
            end
            default: cmd.res_ok = 1'b1;
          endcase
        end
      end
      ST_INSERT: begin
        cmd.ins = 1'b1;
        cmd.res_ok = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
        if (sts.rd_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/sds_datapath.sv
// Datapath of the sorted deque store: cell chain, count and result register.
module sds_datapath #(
  parameter int CAPACITY = sds_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sds_pkg::cmd_t                     cmd,
  output sds_pkg::sts_t                     sts,
  input  logic [2:0]                        operation,
  input  logic signed [sds_pkg::KEY_W-1:0]  sort_key,
  input  logic [sds_pkg::ID_W-1:0]          id_chars,
  input  logic [sds_pkg::NAME_W-1:0]        name_handle,
  output logic                              result_valid,
  output logic [1:0]                        status,
  output logic signed [sds_pkg::KEY_W-1:0]  out_key,
  output logic [sds_pkg::ID_W-1:0]          out_id,
  output logic [sds_pkg::NAME_W-1:0]        out_name_handle,
  output logic                              last_of_run
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  sds_pkg::rec_t cells [CAPACITY];
  sds_pkg::rec_t in_rec;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_left;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] tail_idx;
  logic [CAPACITY-1:0] valid, ge, g_new, g_q, iso, shift_up;

  assign count_m1 = count - CNT_W'(1);
  assign tail_idx = count_m1[IDX_W-1:0];

  assign sts.empty   = (count == '0);
  assign sts.full    = (count == CNT_W'(CAPACITY));
  assign sts.rd_last = (rd_left == CNT_W'(1));

  // A set bit marks a cell at or after which the new record may go.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (CNT_W'(i) < count);
      ge[i] = (cells[i].key >= sort_key);
    end
    unique case (sds_pkg::op_t'(operation))
      sds_pkg::OP_PUSH_HEAD: g_new = '1;
      sds_pkg::OP_PUSH_TAIL: g_new = ~valid;
      default:               g_new = ge | ~valid;
    endcase
  end

  // Lowest set bit is the insert position; every cell above it moves up.
  assign iso = g_q & (~g_q + CAPACITY'(1));
  assign shift_up = ~(iso - CAPACITY'(1)) & ~iso;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      in_rec.key  <= sort_key;
      in_rec.id   <= id_chars;
      in_rec.name <= name_handle;
      g_q <= g_new;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sds_pkg::rec_t below, above;
    if (i == 0) begin : g_head
      assign below = cells[i];
    end else begin : g_body
      assign below = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign above = cells[i];
    end else begin : g_mid
      assign above = cells[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.ins) begin
        if (iso[i]) cells[i] <= in_rec;
        else if (shift_up[i]) cells[i] <= below;
      end else if (cmd.pop_h) begin
        cells[i] <= above;
      end else if (cmd.rd_step) begin
        // Rotate the stored run by one so the next entry sits at the head.
        if (CNT_W'(i) == count_m1) cells[i] <= cells[0];
        else if (CNT_W'(i) < count_m1) cells[i] <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_left <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clr) count <= '0;
      else if (cmd.ins) count <= count + CNT_W'(1);
      else if (cmd.pop_h || cmd.pop_t) count <= count_m1;

      if (cmd.rd_load) rd_left <= count;
      else if (cmd.rd_step) rd_left <= rd_left - CNT_W'(1);

      result_valid <= cmd.res_ok | cmd.res_empty | cmd.res_full |
                      cmd.pop_h | cmd.pop_t | cmd.rd_step;
    end
  end

  always_ff @(posedge clk) begin
    status <= sds_pkg::STAT_OK;
    out_key <= '0;
    out_id <= '0;
    out_name_handle <= '0;
    last_of_run <= 1'b1;
    if (cmd.res_empty) begin
      status <= sds_pkg::STAT_EMPTY;
    end else if (cmd.res_full) begin
      status <= sds_pkg::STAT_FULL;
    end else if (cmd.pop_h || cmd.rd_step) begin
      out_key <= cells[0].key;
      out_id <= cells[0].id;
      out_name_handle <= cells[0].name;
      last_of_run <= cmd.pop_h | sts.rd_last;
    end else if (cmd.pop_t) begin
      out_key <= cells[tail_idx].key;
      out_id <= cells[tail_idx].id;
      out_name_handle <= cells[tail_idx].name;
    end
  end

endmodule

>>> rtl/sorted_deque_store_top.sv
// Pop, clear and refused items give their result in the cycle after acceptance;
// pushes and sorted inserts give theirs after a position capture, then a cell shift.
// Pop and clear take one item per cycle; a push keeps the block busy until its insert is done,
// and a read-all keeps it busy while it streams one entry per cycle off the chain head.
// Reset empties the store at once; results cannot be stalled by the receiver.
module sorted_deque_store_top #(
  parameter int CAPACITY = sds_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        operation,
  input  logic signed [sds_pkg::KEY_W-1:0]  sort_key,
  input  logic [sds_pkg::ID_W-1:0]          id_chars,
  input  logic [sds_pkg::NAME_W-1:0]        name_handle,
  output logic                              result_valid,
  output logic [1:0]                        status,
  output logic signed [sds_pkg::KEY_W-1:0]  out_key,
  output logic [sds_pkg::ID_W-1:0]          out_id,
  output logic [sds_pkg::NAME_W-1:0]        out_name_handle,
  output logic                              last_of_run
);

  sds_pkg::cmd_t cmd;
  sds_pkg::sts_t sts;

  sds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  sds_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (operation),
    .sort_key        (sort_key),
    .id_chars        (id_chars),
    .name_handle     (name_handle),
    .result_valid    (result_valid),
    .status          (status),
    .out_key         (out_key),
    .out_id          (out_id),
    .out_name_handle (out_name_handle),
    .last_of_run     (last_of_run)
  );

endmodule

>>> rtl/sds_checker.sv
// Port-level checks of the sorted deque store, bound to the top level.
module sds_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [2:0]                        operation,
  input logic                              result_valid,
  input logic [1:0]                        status,
  input logic signed [sds_pkg::KEY_W-1:0]  out_key,
  input logic [sds_pkg::ID_W-1:0]          out_id,
  input logic [sds_pkg::NAME_W-1:0]        out_name_handle,
  input logic                              last_of_run
);

  // A read-out run has no gaps.
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |=> result_valid)
    else $error("read-out run broken");

  // The block stays busy while a run is still going.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |-> busy)
    else $error("idle in the middle of a run");

  // A clear answers in the next cycle with a single ok result.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == sds_pkg::OP_CLEAR |=>
      result_valid && last_of_run && status == sds_pkg::STAT_OK)
    else $error("clear result wrong");

  // A refused push carries no record.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == sds_pkg::STAT_FULL |->
      out_key == '0 && out_id == '0 && out_name_handle == '0 && last_of_run)
    else $error("full result carries a record");

endmodule

bind sorted_deque_store_top sds_checker u_sds_checker (.*);

>>> tb/sv/deque_store_checker.sv
`timescale 1ns / 1ps
// Checker that mirrors the sorted deque store and compares every result it emits.
module deque_store_checker #(
  parameter int CAPACITY = sds_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [2:0]                       operation,
  input  logic signed [sds_pkg::KEY_W-1:0] sort_key,
  input  logic [sds_pkg::ID_W-1:0]         id_chars,
  input  logic [sds_pkg::NAME_W-1:0]       name_handle,
  input  logic                             result_valid,
  input  logic [1:0]                       status,
  input  logic signed [sds_pkg::KEY_W-1:0] out_key,
  input  logic [sds_pkg::ID_W-1:0]         out_id,
  input  logic [sds_pkg::NAME_W-1:0]       out_name_handle,
  input  logic                             last_of_run,
  output int                               failures,
  output int                               outstanding
);
  import sds_pkg::*;

  typedef struct packed {
    status_t                 code;
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
    logic [NAME_W-1:0]       name;
    logic                    last;
  } reply_t;

  rec_t   cells [CAPACITY];
  int     stored = 0;
  int     fail_count = 0;
  reply_t awaited_replies [$];

  assign failures = fail_count;

  task automatic expect_reply(input status_t code, input rec_t r, input logic last);
    reply_t exp;
    exp.code = code;
    exp.key = r.key;
    exp.id = r.id;
    exp.name = r.name;
    exp.last = last;
    awaited_replies.push_back(exp);
  endtask

  task automatic apply_item();
    int   pos;
    int   i;
    rec_t incoming;
    incoming.key = sort_key;
    incoming.id = id_chars;
    incoming.name = name_handle;
    case (operation) inside
      OP_PUSH_HEAD, OP_PUSH_TAIL, OP_SORTED: begin
        if (stored >= CAPACITY) begin
          expect_reply(STAT_FULL, '0, 1'b1);
        end else begin
          pos = (operation == OP_PUSH_HEAD) ? 0 : stored;
          // Scanning from the tail leaves pos at the first entry whose key is not smaller.
          if (operation == OP_SORTED) begin
            for (i = stored - 1; i >= 0; i--)
              if ($signed(cells[i].key) >= $signed(sort_key)) pos = i;
          end
          for (i = stored; i > pos; i--) cells[i] = cells[i-1];
          cells[pos] = incoming;
          stored++;
          expect_reply(STAT_OK, '0, 1'b1);
        end
      end
      OP_POP_HEAD: begin
        if (stored == 0) begin
          expect_reply(STAT_EMPTY, '0, 1'b1);
        end else begin
          expect_reply(STAT_OK, cells[0], 1'b1);
          for (i = 1; i < stored; i++) cells[i-1] = cells[i];
          stored--;
        end
      end
      OP_POP_TAIL: begin
        if (stored == 0) begin
          expect_reply(STAT_EMPTY, '0, 1'b1);
        end else begin
          stored--;
          expect_reply(STAT_OK, cells[stored], 1'b1);
        end
      end
      OP_CLEAR: begin
        stored = 0;
        expect_reply(STAT_OK, '0, 1'b1);
      end
      OP_READ_ALL: begin
        if (stored == 0) begin
          expect_reply(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < stored; i++) expect_reply(STAT_OK, cells[i], i == stored - 1);
        end
      end
      default: begin
        expect_reply(STAT_OK, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_reply();
    reply_t exp;
    if (awaited_replies.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: status %0d key %0d id %h name %h last %b",
                 status, out_key, out_id, out_name_handle, last_of_run);
    end else begin
      exp = awaited_replies.pop_front();
      if (status !== exp.code || out_key !== exp.key || out_id !== exp.id ||
          out_name_handle !== exp.name || last_of_run !== exp.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected status %0d key %0d id %h name %h last %b,",
                   exp.code, exp.key, exp.id, exp.name, exp.last);
          $display("  got status %0d key %0d id %h name %h last %b",
                   status, out_key, out_id, out_name_handle, last_of_run);
        end
      end
    end
  endtask

  // Results of older items are retired before the item accepted at this edge is modeled.
  always @(posedge clk) begin
    if (rst) begin
      stored = 0;
      awaited_replies.delete();
    end else begin
      if (result_valid) check_reply();
      if (start && !busy) apply_item();
    end
    outstanding = awaited_replies.size();
  end

endmodule

>>> tb/sv/sorted_deque_store_top_test.sv
`timescale 1ns / 1ps
// Top of the sorted deque store testbench: clock, reset, item stimulus and verdict.
module sorted_deque_store_top_test;
  import sds_pkg::*;

  localparam int         STORE_DEPTH = CAPACITY_DEF;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int         RANDOM_ITEMS = 320;
  localparam int         CALM_TAIL = 60;
  localparam int         PH_FILL = 0;
  localparam int         PH_DRAIN = 1;
  localparam int         PH_MIXED = 2;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [2:0]          operation;
  logic signed [31:0]  sort_key;
  logic [ID_W-1:0]     id_chars;
  logic [NAME_W-1:0]   name_handle;
  logic                result_valid;
  logic [1:0]          status;
  logic signed [31:0]  out_key;
  logic [ID_W-1:0]     out_id;
  logic [NAME_W-1:0]   out_name_handle;
  logic                last_of_run;
  int                  failures;
  int                  outstanding;
  int                  idle_pct;

  sorted_deque_store_top #(.CAPACITY(STORE_DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .sort_key(sort_key), .id_chars(id_chars),
    .name_handle(name_handle), .result_valid(result_valid), .status(status),
    .out_key(out_key), .out_id(out_id), .out_name_handle(out_name_handle),
    .last_of_run(last_of_run)
  );

  deque_store_checker #(.CAPACITY(STORE_DEPTH)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .sort_key(sort_key), .id_chars(id_chars),
    .name_handle(name_handle), .result_valid(result_valid), .status(status),
    .out_key(out_key), .out_id(out_id), .out_name_handle(out_name_handle),
    .last_of_run(last_of_run), .failures(failures), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Busy is read at the falling edge, where it is stable; the item goes in at the next rise.
  task automatic send_item(input logic [2:0] op, input logic signed [31:0] key,
                           input logic [ID_W-1:0] id, input logic [NAME_W-1:0] name);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    sort_key <= key;
    id_chars <= id;
    name_handle <= name;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Keys cluster near zero and at the extremes so that equal keys are common.
  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 5)) inside
      0: k = 32'sh7fffffff;
      1: k = 32'sh80000000;
      2, 3: k = $urandom_range(0, 6) - 3;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ID_W-1:0];
  endfunction

  function automatic logic [2:0] choose_op(input int kind);
    int         r;
    logic [2:0] push_op;
    logic [2:0] pop_op;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: push_op = OP_PUSH_HEAD;
      1: push_op = OP_PUSH_TAIL;
      default: push_op = OP_SORTED;
    endcase
    pop_op = $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
    case (kind)
      PH_FILL: return (r < 85) ? push_op : (r < 93) ? OP_READ_ALL : pop_op;
      PH_DRAIN: return (r < 75) ? pop_op : (r < 87) ? OP_READ_ALL : push_op;
      default: begin
        if (r < 45) return push_op;
        if (r < 80) return pop_op;
        if (r < 91) return OP_READ_ALL;
        if (r < 96) return OP_CLEAR;
        return OP_UNUSED;
      end
    endcase
  endfunction

  initial begin
    int sent;
    int kind;
    int n;
    rst <= 1'b1;
    start <= 1'b0;
    operation <= OP_PUSH_HEAD;
    sort_key <= '0;
    id_chars <= '0;
    name_handle <= '0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pops and read-out on an empty store, then a single-entry pop.
    send_item(OP_POP_HEAD, 32'sd0, '0, '0);
    send_item(OP_POP_TAIL, 32'sd0, '0, '0);
    send_item(OP_READ_ALL, 32'sd0, '0, '0);
    send_item(OP_PUSH_HEAD, 32'sh7fffffff, '1, '1);
    send_item(OP_POP_TAIL, 32'sd0, '0, '0);
    send_item(OP_READ_ALL, 32'sd0, '0, '0);
    send_item(OP_PUSH_HEAD, 32'sh7fffffff, '1, '1);
    send_item(OP_POP_HEAD, 32'sd0, '0, '0);
    send_item(OP_POP_HEAD, 32'sd0, '0, '0);
    // An equal key on a sorted insert must land at the head.
    send_item(OP_PUSH_TAIL, 32'sh80000000, '0, '0);
    send_item(OP_SORTED, 32'sh80000000, 40'h4142434445, 16'h1234);
    send_item(OP_SORTED, 32'sh7fffffff, 40'h5a5a5a5a5a, 16'hfffe);
    send_item(OP_SORTED, 32'sd0, 40'h3031323334, 16'h0001);
    send_item(OP_PUSH_HEAD, -32'sd1, '1, 16'h8000);
    send_item(OP_READ_ALL, 32'sd0, '0, '0);
    send_item(OP_POP_HEAD, 32'sd0, '0, '0);
    send_item(OP_POP_TAIL, 32'sd0, '0, '0);
    send_item(OP_UNUSED, 32'sd5, '1, '1);
    send_item(OP_READ_ALL, 32'sd0, '0, '0);
    send_item(OP_CLEAR, 32'sd0, '0, '0);
    send_item(OP_READ_ALL, 32'sd0, '0, '0);
    send_item(OP_POP_TAIL, 32'sd0, '0, '0);
    drain_results();

    // The first phase fills the store well past capacity so pushes get refused.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = (sent == 0) ? PH_FILL : $urandom_range(PH_FILL, PH_MIXED);
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
      for (n = 0; n < 24 && sent < RANDOM_ITEMS; n++) begin
        if (sent >= RANDOM_ITEMS - CALM_TAIL) idle_pct = 0;
        send_item(choose_op(kind), pick_key(), pick_id(), 16'($urandom));
        sent++;
      end
      if ($urandom_range(0, 2) == 0 && sent < RANDOM_ITEMS - CALM_TAIL) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sds_pkg.sv
rtl/sds_ctrl.sv
rtl/sds_datapath.sv
rtl/sorted_deque_store_top.sv
rtl/sds_checker.sv
tb/sv/deque_store_checker.sv
tb/sv/sorted_deque_store_top_test.sv
